FILE: sv/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and defaults of the LFU replacement policy unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

   localparam int WAYS_DEFAULT       = 8;
   localparam int SETS_DEFAULT       = 256;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int FUNC_BITS   = 2;
   localparam int SET_IN_BITS = 8;
   localparam int WAY_IN_BITS = 3;
   localparam int WAY_OUT_BITS   = 3;
   localparam int COUNT_OUT_BITS = 16;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_INVALIDATE = 2'd0,
      FUNC_TOUCH      = 2'd1,
      FUNC_FILL       = 2'd2,
      FUNC_QUERY      = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: sv/lfu_req_if.sv
// ----------------------------------------------------------------------------
// lfu_req_if
// Request channel: operation, set and way, with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfu_req_if;
   logic                           valid;
   logic                           ready;
   logic [lfu_pkg::FUNC_BITS-1:0]   func;
   logic [lfu_pkg::SET_IN_BITS-1:0] set_index;
   logic [lfu_pkg::WAY_IN_BITS-1:0] way_index;

   modport source (output valid, output func, output set_index, output way_index,
                   input ready);
   modport sink   (input valid, input func, input set_index, input way_index,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/lfu_rsp_if.sv
// ----------------------------------------------------------------------------
// lfu_rsp_if
// Response channel: victim way and its count, with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfu_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lfu_pkg::WAY_OUT_BITS-1:0]   victim_way;
   logic [lfu_pkg::COUNT_OUT_BITS-1:0] victim_count;

   modport source (output valid, output victim_way, output victim_count, input ready);
   modport sink   (input valid, input victim_way, input victim_count, output ready);
endinterface

`default_nettype wire

FILE: sv/lfu_replacement_policy_unit.sv
// ----------------------------------------------------------------------------
// lfu_replacement_policy_unit
// Least-frequently-used replacement policy with saturating per-way counters.
// ----------------------------------------------------------------------------
// After reset the unit clears the counter memory, one set row per cycle, and
// takes no request meanwhile. Requests are handled one at a time, each set
// being one row of a single-port-read counter RAM: an invalidate, touch or
// fill reads the row, then writes the modified row back if the way is in
// range; a victim query reads the row, runs a serial minimum search one way
// per cycle and hands the result to the output register once that is free,
// before the next request is taken. The response word sits in an output
// register, so a new request is accepted while an earlier one waits on rsp_if.ready.
`default_nettype none

module lfu_replacement_policy_unit #(
   parameter int WAYS       = lfu_pkg::WAYS_DEFAULT,
   parameter int SETS       = lfu_pkg::SETS_DEFAULT,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lfu_req_if.sink    req_if,
   lfu_rsp_if.source  rsp_if
);

   import lfu_pkg::*;

   localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS = $clog2(WAYS);
   localparam int ROW_BITS = WAYS * COUNT_BITS;
   localparam int SET_SPAN = 1 << SET_IN_BITS;
   localparam logic [SET_BITS-1:0] LAST_SET = SET_BITS'(SETS - 1);

   state_type              state_ff, state_in;
   logic [SET_BITS-1:0]    clr_ff, clr_in;
   func_type               func_ff, func_in;
   logic [WAY_IN_BITS-1:0] way_ff, way_in;
   logic [SET_BITS-1:0]    set_ff, set_in;
   logic                   hit_ff, hit_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [WAY_OUT_BITS-1:0]   rsp_way_ff, rsp_way_in;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic                  accept;
   logic [SET_BITS-1:0]   set_map [SET_SPAN];
   logic                  ram_we;
   logic [SET_BITS-1:0]   ram_waddr;
   logic [ROW_BITS-1:0]   ram_wdata;
   logic [ROW_BITS-1:0]   rd_row;
   logic [ROW_BITS-1:0]   new_row;
   logic                  scan_start;
   logic                  scan_done;
   logic [WAY_BITS-1:0]   best_way;
   logic [COUNT_BITS-1:0] best_count;

   // set_index modulo SETS, resolved at elaboration
   for (genvar i = 0; i < SET_SPAN; i++) begin : g_set_map
      assign set_map[i] = SET_BITS'(i % SETS);
   end

   assign accept = req_if.valid && req_if.ready;

   lfu_ram #(
      .DEPTH     (SETS),
      .WIDTH     (ROW_BITS),
      .ADDR_BITS (SET_BITS)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_en      (accept),
      .rd_addr    (set_map[req_if.set_index]),
      .rd_data_ff (rd_row)
   );

   lfu_scan #(
      .WAYS       (WAYS),
      .COUNT_BITS (COUNT_BITS),
      .WAY_BITS   (WAY_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .start         (scan_start),
      .row           (rd_row),
      .done          (scan_done),
      .best_way_ff   (best_way),
      .best_count_ff (best_count)
   );

   // read-modify of the one addressed way
   always_comb begin
      new_row = rd_row;
      for (int w = 0; w < WAYS; w++) begin
         if (hit_ff && (int'(way_ff) == w)) begin
            case (func_ff)
               FUNC_INVALIDATE: new_row[w*COUNT_BITS +: COUNT_BITS] = '0;
               FUNC_TOUCH: begin
                  if (!(&rd_row[w*COUNT_BITS +: COUNT_BITS])) begin
                     new_row[w*COUNT_BITS +: COUNT_BITS] =
                        rd_row[w*COUNT_BITS +: COUNT_BITS] + COUNT_BITS'(1);
                  end
               end
               FUNC_FILL: new_row[w*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'(1);
               default: new_row[w*COUNT_BITS +: COUNT_BITS] =
                           rd_row[w*COUNT_BITS +: COUNT_BITS];
            endcase
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      func_in      = func_ff;
      way_in       = way_ff;
      set_in       = set_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_way_in   = rsp_way_ff;
      rsp_count_in = rsp_count_ff;
      ram_we       = 1'b0;
      ram_waddr    = set_ff;
      ram_wdata    = new_row;
      scan_start   = 1'b0;
      req_if.ready = 1'b0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + SET_BITS'(1);
            if (clr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               func_in  = func_type'(req_if.func);
               way_in   = req_if.way_index;
               set_in   = set_map[req_if.set_index];
               hit_in   = int'(req_if.way_index) < WAYS;
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            if (func_ff == FUNC_QUERY) begin
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end else begin
               ram_we   = hit_ff;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_way_in   = WAY_OUT_BITS'(best_way);
               rsp_count_in = COUNT_OUT_BITS'(best_count);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      way_ff       <= way_in;
      set_ff       <= set_in;
      hit_ff       <= hit_in;
      rsp_way_ff   <= rsp_way_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.victim_way   = rsp_way_ff;
   assign rsp_if.victim_count = rsp_count_ff;

   // no request is taken while the memory is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_if.ready)
      else $error("request accepted during clearing pass");

   // a query never writes the counter memory back
   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY && func_ff == FUNC_QUERY) |-> !ram_we)
      else $error("victim query wrote counter row");

   // a new response word only follows a finished scan
   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response without completed scan");

   // scan completion is only seen while waiting for it
   a_scan_done_state: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> state_ff == ST_SCAN)
      else $error("scan finished outside scan state");

endmodule

`default_nettype wire

FILE: sv/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram
// Counter memory: one row per set, all ways side by side. One write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ram #(
   parameter int DEPTH     = lfu_pkg::SETS_DEFAULT,
   parameter int WIDTH     = lfu_pkg::WAYS_DEFAULT * lfu_pkg::COUNT_BITS_DEFAULT,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/lfu_scan.sv
// ----------------------------------------------------------------------------
// lfu_scan
// Serial minimum search over the ways of one row, one way per cycle.
// Strict less-than keeps the lowest way on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_scan #(
   parameter int WAYS       = lfu_pkg::WAYS_DEFAULT,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEFAULT,
   parameter int WAY_BITS   = $clog2(WAYS)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [WAYS*COUNT_BITS-1:0] row,
   output logic                            done,
   output logic      [WAY_BITS-1:0]        best_way_ff,
   output logic      [COUNT_BITS-1:0]      best_count_ff
);

   localparam logic [WAY_BITS-1:0] LAST_WAY = WAY_BITS'(WAYS - 1);

   logic [COUNT_BITS-1:0] cnt [WAYS];
   logic                  busy_ff, busy_in;
   logic [WAY_BITS-1:0]   idx_ff, idx_in;
   logic [WAY_BITS-1:0]   best_way_in;
   logic [COUNT_BITS-1:0] best_count_in;

   for (genvar w = 0; w < WAYS; w++) begin : g_unpack
      assign cnt[w] = row[w*COUNT_BITS +: COUNT_BITS];
   end

   assign done = busy_ff && (idx_ff == LAST_WAY);

   always_comb begin
      busy_in       = busy_ff;
      idx_in        = idx_ff;
      best_way_in   = best_way_ff;
      best_count_in = best_count_ff;
      if (start) begin
         busy_in       = 1'b1;
         idx_in        = WAY_BITS'(1);
         best_way_in   = '0;
         best_count_in = cnt[0];
      end else if (busy_ff) begin
         if (cnt[idx_ff] < best_count_ff) begin
            best_way_in   = idx_ff;
            best_count_in = cnt[idx_ff];
         end
         idx_in = idx_ff + WAY_BITS'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      best_way_ff   <= best_way_in;
      best_count_ff <= best_count_in;
   end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lfu_replacement_policy_unit. Streams invalidate,
// touch, fill and victim-query words at the request channel with bursty
// timing, predicts each victim from a shadow copy of the per-way counters,
// and checks every response word against it under random backpressure.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lfu_pkg::*;

   localparam int NUM_WAYS     = WAYS_DEFAULT;
   localparam int NUM_SETS     = SETS_DEFAULT;
   localparam int CNT_BITS     = COUNT_BITS_DEFAULT;
   localparam int RANDOM_WORDS = 1020;
   localparam int HEAVY_TOUCHES = 200;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int SETTLE_CYCLES = 4 * (NUM_WAYS + 2);
   localparam logic [CNT_BITS-1:0] COUNT_TOP = '1;

   typedef struct {
      func_type               op;
      logic [SET_IN_BITS-1:0] set_idx;
      logic [WAY_IN_BITS-1:0] way_idx;
      bit                     drain_first;
   } access_type;

   typedef struct {
      logic [WAY_OUT_BITS-1:0]   way;
      logic [COUNT_OUT_BITS-1:0] count;
   } victim_type;

   typedef enum {RX_OPEN, RX_CHOPPY, RX_SPARSE, RX_HOLD} rx_mode_type;

   logic clock;
   logic reset;

   lfu_req_if req_if ();
   lfu_rsp_if rsp_if ();

   lfu_replacement_policy_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   access_type          pending_words[$];
   victim_type          expected_victims[$];
   logic [CNT_BITS-1:0] way_counts [NUM_SETS][NUM_WAYS];

   logic        word_fired;
   int          words_accepted;
   int          words_total;
   int          random_start;
   int          results_checked;
   int          saturated_touches;
   int          errors;
   int          cycle_count;
   int          gap_left;
   int          burst_left;
   int          stall_left;
   int          hold_offs;
   int          longest_hold;
   rx_mode_type rx_mode;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.func = FUNC_INVALIDATE;
      req_if.set_index = '0;
      req_if.way_index = '0;
      rsp_if.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_word(func_type op, logic [SET_IN_BITS-1:0] set_idx,
                                      logic [WAY_IN_BITS-1:0] way_idx, bit drain_first);
      access_type word;
      word.op = op;
      word.set_idx = set_idx;
      word.way_idx = way_idx;
      word.drain_first = drain_first;
      pending_words.push_back(word);
   endfunction

   // Shadow counter update; a victim query pushes the predicted response word.
   function automatic void apply_access(func_type op, logic [SET_IN_BITS-1:0] set_idx,
                                        logic [WAY_IN_BITS-1:0] way_idx);
      int                  row;
      int                  best_way;
      logic [CNT_BITS-1:0] best_count;
      victim_type          victim;
      row = set_idx % NUM_SETS;
      if (op == FUNC_QUERY) begin
         best_way = 0;
         best_count = way_counts[row][0];
         for (int w = 1; w < NUM_WAYS; w++) begin
            if (way_counts[row][w] < best_count) begin
               best_way = w;
               best_count = way_counts[row][w];
            end
         end
         victim.way = best_way[WAY_OUT_BITS-1:0];
         victim.count = COUNT_OUT_BITS'(best_count);
         expected_victims.push_back(victim);
         return;
      end
      if (way_idx >= NUM_WAYS)
         return;
      case (op)
         FUNC_INVALIDATE: way_counts[row][way_idx] = '0;
         FUNC_TOUCH: begin
            if (way_counts[row][way_idx] == COUNT_TOP)
               saturated_touches++;
            else
               way_counts[row][way_idx] = way_counts[row][way_idx] + 1'b1;
         end
         FUNC_FILL: way_counts[row][way_idx] = 1;
         default: ;
      endcase
   endfunction

   // request side: acceptance and prediction
   always @(posedge clock) begin
      if (reset) begin
         foreach (way_counts[s, w])
            way_counts[s][w] = '0;
         word_fired <= 1'b0;
      end else begin
         word_fired <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            words_accepted++;
            apply_access(func_type'(req_if.func), req_if.set_index, req_if.way_index);
         end
      end
   end

   always @(negedge clock) begin : word_driver
      access_type next_word;
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else if (!req_if.valid || word_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_words.size() != 0 &&
                      !(pending_words[0].drain_first && expected_victims.size() != 0)) begin
            next_word = pending_words.pop_front();
            req_if.func <= next_word.op;
            req_if.set_index <= next_word.set_idx;
            req_if.way_index <= next_word.way_idx;
            req_if.valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 50);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response backpressure: open, choppy and sparse stretches, plus long
   // hold-offs once the random traffic is running.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         rx_mode = RX_OPEN;
      end else begin
         if (stall_left == 0) begin
            if (words_accepted >= random_start &&
                (hold_offs == 0 || (hold_offs < 4 && $urandom_range(0, 150) == 0))) begin
               rx_mode = RX_HOLD;
               stall_left = $urandom_range(200, 400);
               hold_offs++;
               if (stall_left > longest_hold)
                  longest_hold = stall_left;
            end else begin
               rx_mode = rx_mode_type'($urandom_range(0, 2));
               stall_left = $urandom_range(4, 60);
            end
         end
         stall_left--;
         case (rx_mode)
            RX_OPEN:   rsp_if.ready <= 1'b1;
            RX_CHOPPY: rsp_if.ready <= $urandom_range(0, 1);
            RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_if.ready <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin : victim_monitor
      victim_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_victims.size() == 0) begin
            $display("%0t: unexpected response word, way %0d count %0d",
                     $time, rsp_if.victim_way, rsp_if.victim_count);
            errors++;
         end else begin
            want = expected_victims.pop_front();
            results_checked++;
            if (rsp_if.victim_way !== want.way) begin
               $display("%0t: victim_way expected %0d, got %0d",
                        $time, want.way, rsp_if.victim_way);
               errors++;
            end
            if (rsp_if.victim_count !== want.count) begin
               $display("%0t: victim_count expected %0d, got %0d",
                        $time, want.count, rsp_if.victim_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out after %0d cycles, %0d words still queued",
                  $time, cycle_count, pending_words.size());
         $display("lfu_replacement_policy_unit: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      logic [SET_IN_BITS-1:0] hot_sets[4];
      int                     pick;
      func_type               op;
      logic [SET_IN_BITS-1:0] set_idx;

      // fresh sets: all-zero ties go to way 0
      queue_word(FUNC_QUERY, 8'h00, 3'd0, 1'b0);
      queue_word(FUNC_QUERY, 8'hFF, 3'd7, 1'b0);
      for (int w = 0; w < NUM_WAYS; w++)
         queue_word(FUNC_FILL, 8'hFF, 3'(w), 1'b0);
      queue_word(FUNC_QUERY, 8'hFF, 3'd5, 1'b0);
      queue_word(FUNC_TOUCH, 8'hFF, 3'd0, 1'b0);
      queue_word(FUNC_QUERY, 8'hFF, 3'd2, 1'b0);
      queue_word(FUNC_INVALIDATE, 8'hFF, 3'd7, 1'b0);
      queue_word(FUNC_QUERY, 8'hFF, 3'd0, 1'b0);
      queue_word(FUNC_TOUCH, 8'hFF, 3'd7, 1'b0);
      queue_word(FUNC_TOUCH, 8'hFF, 3'd7, 1'b0);
      queue_word(FUNC_QUERY, 8'hFF, 3'd7, 1'b0);
      queue_word(FUNC_FILL, 8'hFF, 3'd0, 1'b0);
      queue_word(FUNC_TOUCH, 8'h5A, 3'd3, 1'b0);
      queue_word(FUNC_QUERY, 8'h5A, 3'd6, 1'b0);
      queue_word(FUNC_INVALIDATE, 8'h00, 3'd7, 1'b0);

      // One heavily used way: a long run of touches has to keep it above
      // the filled ways, so it never shows up as the victim.
      for (int w = 1; w < NUM_WAYS; w++)
         queue_word(FUNC_FILL, 8'hA5, 3'(w), w == 1);
      for (int i = 0; i < HEAVY_TOUCHES; i++)
         queue_word(FUNC_TOUCH, 8'hA5, 3'd0, 1'b0);
      queue_word(FUNC_QUERY, 8'hA5, 3'd0, 1'b0);
      queue_word(FUNC_TOUCH, 8'hA5, 3'd0, 1'b0);
      queue_word(FUNC_INVALIDATE, 8'hA5, 3'd3, 1'b0);
      queue_word(FUNC_QUERY, 8'hA5, 3'd3, 1'b0);

      // random traffic, mostly on a few hot sets so counts build up
      random_start = pending_words.size();
      hot_sets[0] = 8'h00;
      hot_sets[1] = 8'hFF;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 300 == 0) begin
            hot_sets[2] = $urandom_range(0, 255);
            hot_sets[3] = $urandom_range(0, 255);
         end
         pick = $urandom_range(0, 99);
         if (pick < 35)
            op = FUNC_TOUCH;
         else if (pick < 50)
            op = FUNC_FILL;
         else if (pick < 65)
            op = FUNC_INVALIDATE;
         else
            op = FUNC_QUERY;
         if ($urandom_range(0, 9) < 7)
            set_idx = hot_sets[$urandom_range(0, 3)];
         else
            set_idx = $urandom_range(0, 255);
         queue_word(op, set_idx, 3'($urandom_range(0, 7)), i % 250 == 0);
      end
      words_total = pending_words.size();

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      while (words_accepted < words_total)
         @(negedge clock);
      while (expected_victims.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d request words, %0d victim results checked",
               words_accepted, results_checked);
      $display("%0d touches on a saturated counter, response side held off %0d times, longest %0d cycles",
               saturated_touches, hold_offs, longest_hold);
      if (errors == 0)
         $display("lfu_replacement_policy_unit: match");
      else
         $display("lfu_replacement_policy_unit: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
sv/lfu_pkg.sv
sv/lfu_req_if.sv
sv/lfu_rsp_if.sv
sv/lfu_ram.sv
sv/lfu_scan.sv
sv/lfu_replacement_policy_unit.sv
bench/testbench.sv
